// ===== rtl/core/tcpq_pkg.sv =====
// Shared types and constants for the two-class priority ticket queue.
// Used by tcpq_cell and two_class_priority_queue_top; depends on nothing.
package tcpq_pkg;

    localparam int TICKET_W = 16;
    localparam int AGE_W    = 7;
    localparam int OCC_W    = 5;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    localparam logic [AGE_W-1:0] AGE_THRESHOLD_RESET = 7'd60;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ     = 2'd0,
        KIND_DEQ     = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_PROMOTE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // One queue entry: ticket in the low bits, then priority, then emergency
    typedef struct packed {
        logic                emg;
        logic                pri;
        logic [TICKET_W-1:0] ticket;
    } entry_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic   do_enq;
        logic   do_del;
        logic   do_pro;
        logic   deq_mode;
        logic   pri_new;
        entry_t new_entry;
    } ctrl_t;

    // Flags and selected entry passed from cell to cell, head toward tail
    typedef struct packed {
        logic   hit_upto;
        logic   ins_shift;
        logic   pro_range;
        entry_t sel;
    } link_t;

endpackage

// ===== rtl/core/tcpq_cell.sv =====
// One queue slot of the priority ticket queue chain.
// Depends on tcpq_pkg for the entry, control and link types.
module tcpq_cell
    import tcpq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          aclk,
    input  ctrl_t         ctrl,
    input  logic [CW-1:0] count,
    input  logic          found,
    input  entry_t        pro_entry,
    input  entry_t        prev_entry,
    input  entry_t        next_entry,
    input  link_t         link_in,
    output link_t         link_out,
    output entry_t        entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid;
    logic   pri_valid;
    logic   match;
    logic   first_hit;

    // Slot occupancy and local compare
    assign valid     = CW'(IDX) < count;
    assign pri_valid = valid & entry_reg.pri;
    assign match     = valid & (ctrl.deq_mode ? (IDX == 0)
                                              : (entry_reg.ticket == ctrl.new_entry.ticket));
    assign first_hit = match & ~link_in.hit_upto;

    // Hand flags and the first matching entry toward the tail
    always_comb begin
        link_out.hit_upto  = link_in.hit_upto | match;
        link_out.ins_shift = ~(valid & (ctrl.pri_new ? entry_reg.pri : 1'b1));
        link_out.pro_range = ~pri_valid & ~link_in.hit_upto;
        link_out.sel       = first_hit ? entry_reg : link_in.sel;
    end

    // Insert, close a gap or re-partition locally
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.do_enq && link_out.ins_shift) begin
            entry_next = link_in.ins_shift ? prev_entry : ctrl.new_entry;
        end else if (ctrl.do_del && found && link_out.hit_upto) begin
            entry_next = next_entry;
        end else if (ctrl.do_pro && found) begin
            if (link_out.pro_range) begin
                entry_next = link_in.pro_range ? prev_entry : pro_entry;
            end else if (first_hit) begin
                entry_next.pri = 1'b1;
                entry_next.emg = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/two_class_priority_queue_top.sv =====
// Top level of the two-class priority ticket queue: cell chain, entry count,
// threshold register and result register. Depends on tcpq_pkg and tcpq_cell.
//
// The queue holds up to CAPACITY tickets in a row of cells; priority entries
// always sit ahead of ordinary ones and each class stays in arrival order.
// Every operation (enqueue, dequeue, remove, emergency promote) completes at
// once: all cells compare against the ticket and shift one slot toward or away
// from their neighbor, so one item is taken per cycle unless the result output
// stalls, and its result appears in the output register on the next cycle. The
// cycle time grows with CAPACITY, since the first-match and insert flags ripple
// through the whole chain. Entry contents are undefined after reset and need no
// clearing pass; the entry count, result valid flag and threshold are reset. The
// age threshold may be written only while no operation is pending.
module two_class_priority_queue_top
    import tcpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // age threshold write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [AGE_W-1:0]    cfg_data,
    // operation stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // age[6:0], health_worker[7], ticket[23:8]
    input  logic [KIND_W-1:0]   s_tuser,   // kind[1:0]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // out_ticket[15:0], out_priority[16],
                                           // out_emergency[17], occupancy[22:18], zero[23]
    output logic [STATUS_W-1:0] m_tuser    // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [AGE_W-1:0]    thr_reg;
    logic                m_valid_reg;
    status_t             status_reg;
    status_t             status_next;
    entry_t              ret_reg;
    entry_t              ret_next;
    logic [OCC_W-1:0]    occ_reg;

    logic                accept;
    kind_t               in_kind;
    logic [AGE_W-1:0]    in_age;
    logic                in_hw;
    logic [TICKET_W-1:0] in_ticket;
    logic                full;
    logic                found;
    ctrl_t               ctrl;
    entry_t              pro_entry;

    link_t               link [0:CAPACITY];
    entry_t              cell_entry [0:CAPACITY-1];

    // Unpack the input transfer
    assign in_kind   = kind_t'(s_tuser);
    assign in_age    = s_tdata[6:0];
    assign in_hw     = s_tdata[7];
    assign in_ticket = s_tdata[23:8];

    assign s_tready  = ~m_valid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    assign full  = count_reg == CW'(CAPACITY);
    assign found = link[CAPACITY].hit_upto;

    // Broadcast the operation to the cells
    always_comb begin
        ctrl.do_enq              = accept & (in_kind == KIND_ENQ) & ~full;
        ctrl.do_del              = accept & ((in_kind == KIND_DEQ) || (in_kind == KIND_REMOVE));
        ctrl.do_pro              = accept & (in_kind == KIND_PROMOTE);
        ctrl.deq_mode            = in_kind == KIND_DEQ;
        ctrl.pri_new             = (in_age >= thr_reg) | in_hw;
        ctrl.new_entry.emg       = 1'b0;
        ctrl.new_entry.pri       = (in_age >= thr_reg) | in_hw;
        ctrl.new_entry.ticket    = in_ticket;
    end

    always_comb begin
        pro_entry     = link[CAPACITY].sel;
        pro_entry.pri = 1'b1;
        pro_entry.emg = 1'b1;
    end

    assign link[0] = '0;

    // Cell chain, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        if (i == 0) begin : g_head
            assign prev_e = '0;
        end else begin : g_body
            assign prev_e = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign next_e = cell_entry[i];
        end else begin : g_mid
            assign next_e = cell_entry[i+1];
        end
        tcpq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .found      (found),
            .pro_entry  (pro_entry),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .entry      (cell_entry[i])
        );
    end

    // Result and new count
    always_comb begin
        status_next = STATUS_OK;
        ret_next    = '0;
        count_next  = count_reg;
        case (in_kind)
            KIND_ENQ: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_DEQ, KIND_REMOVE: begin
                if (!found) begin
                    status_next = (in_kind == KIND_DEQ) ? STATUS_EMPTY : STATUS_NOT_FOUND;
                end else begin
                    ret_next   = link[CAPACITY].sel;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_PROMOTE: begin
                if (!found) begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            thr_reg     <= AGE_THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            ret_reg    <= ret_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, occ_reg, ret_reg.emg, ret_reg.pri, ret_reg.ticket};

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_kind == KIND_ENQ && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not add one entry");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_kind == KIND_ENQ && full |=> m_tuser == STATUS_FULL && $stable(count_reg))
        else $error("enqueue on full queue changed state");

    a_deq_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_kind == KIND_DEQ && count_reg == '0 |=> m_tvalid && m_tuser == STATUS_EMPTY)
        else $error("dequeue on empty queue not flagged");

endmodule
